// ----- sv/attc_pkg.sv -----
// attc_pkg: request and response types, opcodes and field widths of the
// associative tag table. No dependencies; used by assoc_tag_table_claim_evict_core and its testbench.
package attc_pkg;

    localparam int KEY_W = 64;
    localparam int REC_W = 64;
    localparam int SEL_W = 4;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_SET    = 2'd1,
        OP_INVAL  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef struct packed {
        t_op              opcode;
        logic [KEY_W-1:0] key_value;
        logic [SEL_W-1:0] slot_sel;
        logic [REC_W-1:0] record_in;
    } t_req;

    typedef struct packed {
        logic [SEL_W-1:0] slot_out;
        logic             hit;
        logic             evicted;
        logic [REC_W-1:0] record_out;
        logic             slot_valid;
    } t_rsp;

endpackage

// ----- sv/assoc_tag_table_claim_evict_core.sv -----
// assoc_tag_table_claim_evict_core: fully associative tag table, top level.
// Depends on attc_pkg and attc_prio_enc.
//
//  channel   | strobe / handshake        | payload
//  ----------+---------------------------+----------------------------
//  request   | start in, busy out        | i_req  (attc_pkg::t_req)
//  response  | o_valid out, one cycle    | o_rsp  (attc_pkg::t_rsp)
//
// one request per cycle while busy is low: the request is registered, the table
// is searched and updated in the following cycle and the response register is
// loaded at its end, together with the o_valid register
// busy is high during reset and for the first cycle after it, never
// otherwise; the receiver cannot stall the response strobe
// reset (synchronous, active low) empties every slot and zeroes every key
module assoc_tag_table_claim_evict_core #(
    parameter int SLOT_COUNT = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  attc_pkg::t_req i_req,
    output logic          o_valid,
    output attc_pkg::t_rsp o_rsp
);

    import attc_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_COUNT - 1);

    // control
    logic r_busy;
    logic r_req_vld;
    logic r_valid;

    // request and response registers
    t_req r_req;
    t_rsp r_rsp;
    t_rsp n_rsp;

    // table: keys, handles and an occupancy bit per slot (handle nonzero)
    logic [KEY_W-1:0]      r_key [SLOT_COUNT];
    logic [REC_W-1:0]      r_rec [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_occ;

    // search results
    logic [SLOT_COUNT-1:0] w_match;
    logic                  w_hit;
    logic [SLOT_COUNT-1:0] w_hit_oh;
    logic [IW-1:0]         w_hit_idx;
    logic                  w_free_any;
    logic [IW-1:0]         w_free_idx;
    logic [IW-1:0]         w_claim_idx;
    logic [REC_W-1:0]      w_hit_rec;

    // addressed slot
    logic                  w_sel_ok;
    logic [IW-1:0]         w_sel_idx;

    // write enables
    logic w_do_lookup;
    logic w_do_claim;
    logic w_do_evict;
    logic w_do_set;
    logic w_do_inval;

    logic w_accept;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_rsp    = r_rsp;

    // parallel key compare against occupied slots
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_match[i] = r_occ[i] && (r_key[i] == r_req.key_value);
        end
    end

    attc_prio_enc #(
        .N (SLOT_COUNT)
    ) u_hit_enc (
        .i_vec    (w_match),
        .o_any    (w_hit),
        .o_onehot (w_hit_oh),
        .o_idx    (w_hit_idx)
    );

    attc_prio_enc #(
        .N (SLOT_COUNT)
    ) u_free_enc (
        .i_vec    (~r_occ),
        .o_any    (w_free_any),
        .o_onehot (),
        .o_idx    (w_free_idx)
    );

    // handle of the matching slot, and-or over the one-hot match
    always_comb begin
        w_hit_rec = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_hit_rec = w_hit_rec | (w_hit_oh[i] ? r_rec[i] : '0);
        end
    end

    // lowest empty slot, or the last slot when the table is full
    assign w_claim_idx = w_free_any ? w_free_idx : LAST_SLOT;

    assign w_sel_ok  = (32'(r_req.slot_sel) < SLOT_COUNT);
    assign w_sel_idx = IW'(r_req.slot_sel);

    assign w_do_lookup = r_req_vld && (r_req.opcode == OP_LOOKUP);
    assign w_do_claim  = w_do_lookup && !w_hit;
    assign w_do_evict  = w_do_claim && !w_free_any;
    assign w_do_set    = r_req_vld && (r_req.opcode == OP_SET) && w_sel_ok;
    assign w_do_inval  = r_req_vld && (r_req.opcode == OP_INVAL) && w_sel_ok;

    // response as seen after the operation
    always_comb begin
        n_rsp            = '0;
        n_rsp.slot_out   = r_req.slot_sel;
        case (r_req.opcode)
            OP_LOOKUP: begin
                n_rsp.slot_out   = SEL_W'(w_hit ? w_hit_idx : w_claim_idx);
                n_rsp.hit        = w_hit;
                n_rsp.evicted    = !w_hit && !w_free_any;
                n_rsp.record_out = w_hit ? w_hit_rec : '0;
            end
            OP_SET: begin
                n_rsp.record_out = w_sel_ok ? r_req.record_in : '0;
            end
            OP_INVAL: begin
                n_rsp.record_out = '0;
            end
            OP_READ: begin
                n_rsp.record_out = (w_sel_ok && r_occ[w_sel_idx]) ? r_rec[w_sel_idx] : '0;
            end
            default: begin
                n_rsp.record_out = '0;
            end
        endcase
        n_rsp.slot_valid = (n_rsp.record_out != '0);
    end

    // control and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_req_vld <= 1'b0;
            r_valid   <= 1'b0;
            r_occ     <= '0;
        end else begin
            r_busy    <= 1'b0;
            r_req_vld <= w_accept;
            r_valid   <= r_req_vld;
            // a claimed slot stays empty; eviction empties the last slot
            if (w_do_evict) begin
                r_occ[LAST_SLOT] <= 1'b0;
            end
            if (w_do_set) begin
                r_occ[w_sel_idx] <= (r_req.record_in != '0);
            end
            if (w_do_inval) begin
                r_occ[w_sel_idx] <= 1'b0;
            end
        end
    end

    // key store: zeroed at reset and by invalidate, written on a claim
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_key[i] <= '0;
            end
        end else begin
            if (w_do_claim) begin
                r_key[w_claim_idx] <= r_req.key_value;
            end
            if (w_do_inval) begin
                r_key[w_sel_idx] <= '0;
            end
        end
    end

    // payload registers and handles
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (r_req_vld) begin
            r_rsp <= n_rsp;
        end
        if (w_do_set) begin
            r_rec[w_sel_idx] <= r_req.record_in;
        end
    end

`ifndef SYNTHESIS
    // every registered request yields exactly one response strobe
    a_one_rsp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_vld |=> o_valid)
        else $error("request did not produce a response");

    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_req_vld |=> !o_valid)
        else $error("response strobe without a request");

    // eviction only reuses the last slot, and only when every slot was full
    a_evict_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.evicted |->
            !o_rsp.hit && !o_rsp.slot_valid && o_rsp.slot_out == SEL_W'(SLOT_COUNT - 1))
        else $error("eviction reported on the wrong slot");

    a_evict_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.evicted |-> $past(&r_occ))
        else $error("eviction while an empty slot existed");

    a_hit_occupied : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> (w_match & ~r_occ) == '0)
        else $error("match on an empty slot");
`endif

endmodule

// ----- sv/attc_prio_enc.sv -----
// attc_prio_enc: lowest-set-bit priority encoder over a slot vector.
// Standalone; instanced by assoc_tag_table_claim_evict_core.
module attc_prio_enc #(
    parameter int N = 16
) (
    input  logic [N-1:0]                         i_vec,
    output logic                                 o_any,
    output logic [N-1:0]                         o_onehot,
    output logic [((N > 1) ? $clog2(N) : 1)-1:0] o_idx
);

    localparam int IW = (N > 1) ? $clog2(N) : 1;

    // isolate the lowest set bit
    assign o_any    = |i_vec;
    assign o_onehot = i_vec & (~i_vec + N'(1));

    always_comb begin
        logic [IW-1:0] v_pos;
        o_idx = '0;
        for (int i = 0; i < N; i++) begin
            v_pos = IW'(i);
            o_idx = o_idx | (o_onehot[i] ? v_pos : '0);
        end
    end

endmodule

// ----- sim/assoc_tag_table_claim_evict_core_tb.sv -----
// testbench for assoc_tag_table_claim_evict_core: directed and random requests checked
// against a shadow copy of the slot table held in a small scoreboard class.
// Depends on attc_pkg and the block's top level only.
module assoc_tag_table_claim_evict_core_tb;
    import attc_pkg::*;

    localparam int SLOTS      = 16;
    localparam int RAND_ITEMS = 1250;
    localparam int POOL_SIZE  = 24;

    // shadow of the slot table plus the queue of responses still awaited
    class tag_table_shadow;
        logic [KEY_W-1:0] keys [SLOTS];
        logic [REC_W-1:0] recs [SLOTS];
        t_rsp             awaited_rsp [$];
        int               fails;
        logic [SEL_W-1:0] last_slot;
        bit               last_hit;

        function new();
            foreach (keys[s]) begin
                keys[s] = '0;
                recs[s] = '0;
            end
            fails = 0;
            last_slot = '0;
            last_hit = 1'b0;
        endfunction

        task report(input string what);
            $display("mismatch @%0t: %s", $time, what);
            fails++;
        endtask

        // update the shadow for one accepted request and queue its response
        function void apply_request(input t_req r);
            t_rsp e;
            int   idx;
            int   free_idx;
            e = '0;
            e.slot_out = r.slot_sel;
            if (r.opcode == OP_LOOKUP) begin
                idx = -1;
                free_idx = -1;
                // scanning downwards leaves the lowest match and lowest empty slot
                for (int s = SLOTS - 1; s >= 0; s--) begin
                    if (recs[s] != '0 && keys[s] == r.key_value)
                        idx = s;
                    if (recs[s] == '0)
                        free_idx = s;
                end
                if (idx >= 0) begin
                    e.hit = 1'b1;
                end else if (free_idx >= 0) begin
                    idx = free_idx;
                    keys[idx] = r.key_value;
                end else begin
                    // table full: the last slot is cleared and reclaimed
                    idx = SLOTS - 1;
                    recs[idx] = '0;
                    keys[idx] = r.key_value;
                    e.evicted = 1'b1;
                end
                e.slot_out = idx[SEL_W-1:0];
                e.record_out = recs[idx];
            end else if (int'(r.slot_sel) < SLOTS) begin
                if (r.opcode == OP_SET) begin
                    recs[r.slot_sel] = r.record_in;
                end else if (r.opcode == OP_INVAL) begin
                    keys[r.slot_sel] = '0;
                    recs[r.slot_sel] = '0;
                end
                e.record_out = recs[r.slot_sel];
            end
            e.slot_valid = (e.record_out != '0);
            last_slot = e.slot_out;
            last_hit = e.hit;
            awaited_rsp.push_back(e);
        endfunction

        task check_response(input t_rsp got);
            t_rsp e;
            if (awaited_rsp.size() == 0) begin
                report("response strobe with no request outstanding");
            end else begin
                e = awaited_rsp.pop_front();
                if (got.slot_out !== e.slot_out)
                    report($sformatf("slot_out %0d, expected %0d", got.slot_out, e.slot_out));
                if (got.hit !== e.hit)
                    report($sformatf("hit %b, expected %b", got.hit, e.hit));
                if (got.evicted !== e.evicted)
                    report($sformatf("evicted %b, expected %b", got.evicted, e.evicted));
                if (got.record_out !== e.record_out)
                    report($sformatf("record_out %h, expected %h",
                                     got.record_out, e.record_out));
                if (got.slot_valid !== e.slot_valid)
                    report($sformatf("slot_valid %b, expected %b",
                                     got.slot_valid, e.slot_valid));
            end
        endtask

        function int outstanding();
            return awaited_rsp.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_valid;
    t_rsp o_rsp;

    tag_table_shadow  sb;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    assoc_tag_table_claim_evict_core #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #100000;
        $display("RESULT: ERROR");
        $finish;
    end

    // responses cannot be held off, so every strobe is checked as it comes
    always @(posedge i_clk) begin
        if (o_valid === 1'b1)
            sb.check_response(o_rsp);
    end

    function automatic t_req mk(input t_op op, input logic [KEY_W-1:0] key,
                                input logic [SEL_W-1:0] sel, input logic [REC_W-1:0] rec);
        t_req r;
        r.opcode = op;
        r.key_value = key;
        r.slot_sel = sel;
        r.record_in = rec;
        return r;
    endfunction

    function automatic logic [REC_W-1:0] nonzero_record();
        logic [REC_W-1:0] v;
        v = {$urandom(), $urandom()};
        if (v == '0)
            v = 64'd1;
        return v;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   p;
        p = $urandom_range(99);
        r.slot_sel = SEL_W'($urandom_range(SLOTS - 1));
        // keys mostly from a small pool so lookups hit and the table fills up
        if ($urandom_range(99) < 80)
            r.key_value = key_pool[$urandom_range(POOL_SIZE - 1)];
        else
            r.key_value = {$urandom(), $urandom()};
        p = $urandom_range(99);
        if (p < 85)
            r.record_in = nonzero_record();
        else if (p < 95)
            r.record_in = '0;
        else
            r.record_in = '1;
        p = $urandom_range(99);
        if (p < 45)
            r.opcode = OP_LOOKUP;
        else if (p < 70)
            r.opcode = OP_SET;
        else if (p < 80)
            r.opcode = OP_INVAL;
        else
            r.opcode = OP_READ;
        return r;
    endfunction

    // hold start high until the block takes the request
    task automatic send(input t_req r);
        start <= 1'b1;
        i_req <= r;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        sb.apply_request(r);
    endtask

    task automatic idle_cycle();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int   n;
        int   guard;
        bit   quiet;
        t_req r;

        sb = new();
        foreach (key_pool[k])
            key_pool[k] = {$urandom(), $urandom()};
        key_pool[0] = '0;
        key_pool[1] = '1;

        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send(mk(OP_READ, '0, 4'd0, '0));               // empty slot after reset
        send(mk(OP_SET, '0, 4'd3, '1));                // slot never claimed, key still zero
        send(mk(OP_LOOKUP, '0, 4'd9, '0));             // hits slot 3 on the reset key
        send(mk(OP_LOOKUP, '1, 4'd0, '1));             // miss, claims slot 0
        send(mk(OP_SET, '0, 4'd0, 64'd1));
        send(mk(OP_LOOKUP, '1, 4'd15, '0));            // hit on slot 0
        send(mk(OP_SET, '1, 4'd0, '0));                // zero handle empties, key kept
        send(mk(OP_INVAL, '1, 4'd3, '1));
        send(mk(OP_READ, '1, 4'd15, '1));
        // fill every slot so that the next miss must evict
        for (int s = 0; s < SLOTS; s++)
            send(mk(OP_SET, '0, SEL_W'(s), REC_W'(s + 1)));
        send(mk(OP_LOOKUP, 64'h0123_4567_89ab_cdef, 4'd0, '0));
        send(mk(OP_READ, '0, 4'd15, '0));

        // random part, with claim-then-set sequences to keep the table populated
        n = 0;
        while (n < RAND_ITEMS) begin
            quiet = (n >= 400 && n < 700);
            if (!quiet && $urandom_range(99) < 6)
                idle_cycle();
            r = random_request();
            send(r);
            n++;
            if (r.opcode == OP_LOOKUP && !sb.last_hit && $urandom_range(99) < 70) begin
                if (!quiet && $urandom_range(99) < 6)
                    idle_cycle();
                send(mk(OP_SET, {$urandom(), $urandom()}, sb.last_slot, nonzero_record()));
                n++;
            end
        end
        start <= 1'b0;

        guard = 0;
        while (sb.outstanding() != 0 && guard < 200) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d responses never arrived", sb.outstanding()));

        if (sb.fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
